>>> design/lrth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrth_pkg
// Shared types, constants and the sigmoid table builder for the two-head
// logistic risk estimator.
// ----------------------------------------------------------------------------
package lrth_pkg;

  // feature vector geometry
  localparam int FEAT_W        = 16;
  localparam int FEAT_LANES    = 8;
  localparam int HALF_LANES    = 4;
  localparam int FEATURE_COUNT = 8;

  // heads
  localparam int NUM_HEADS = 2;
  localparam int HEAD_OBS  = 0;
  localparam int HEAD_DROP = 1;

  // arithmetic widths
  localparam int FB_W     = 17;
  localparam int PROB_W   = 16;
  localparam int ICPT_W   = 32;
  localparam int WREG_W   = 64;
  localparam int FLAGS_W  = 5;
  localparam int PROD_W   = 32;
  localparam int PSUM_W   = 34;
  localparam int LOGIT_W  = 36;

  // saturation and table indexing
  localparam int LOGIT_LIMIT = 1966080;
  localparam int MAG_W       = $clog2(LOGIT_LIMIT);
  localparam int IDX_SHIFT   = 10;
  localparam int IDX_FULL_W  = MAG_W - IDX_SHIFT;
  localparam int SIG_DEPTH   = 1024;
  localparam int SIG_ADDR_W  = $clog2(SIG_DEPTH);

  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(32768);

  // model flag bits
  localparam int FLAG_MODEL_ON   = 0;
  localparam int FLAG_HEAD_ON    = 1;
  localparam int FLAG_HEAD_W     = 3;

  // config bus
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  // register indexes, one 8-byte slot each
  localparam int NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_FLAGS,
    REG_OBS_ICPT,
    REG_DROP_ICPT,
    REG_OBS_WLO,
    REG_OBS_WHI,
    REG_DROP_WLO,
    REG_DROP_WHI
  } cfg_reg_e;

  // exp(-1/64) in Q0.32
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef feat_t [FEAT_LANES-1:0] feat_vec_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]                  flags;
    logic [NUM_HEADS-1:0][ICPT_W-1:0]    intercept;
    logic [NUM_HEADS-1:0][WREG_W-1:0]    w_low;
    logic [NUM_HEADS-1:0][WREG_W-1:0]    w_high;
  } cfg_t;

  typedef struct packed {
    logic                  sat_hi;
    logic                  sat_lo;
    logic                  neg;
    logic [SIG_ADDR_W-1:0] addr;
  } lut_req_t;

  typedef logic [PROB_W-1:0] sig_rom_t [SIG_DEPTH];

  // sigmoid table: entry k = round(2^47 / (2^32 + e_k)), e_k = exp(-k/64) in Q32
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] rem;
    logic [16:0] q;
    e = 64'h1_0000_0000;
    for (int k = 0; k < SIG_DEPTH; k++) begin
      den = 64'h1_0000_0000 + e;
      rem = (64'd1 << 47) + (den >> 1);
      q   = '0;
      // restoring long division, one quotient bit a step
      for (int b = 16; b >= 0; b--) begin
        if (rem >= (den << b)) begin
          rem  = rem - (den << b);
          q[b] = 1'b1;
        end
      end
      rom[k] = q[PROB_W-1:0];
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return rom;
  endfunction

endpackage

>>> design/lrth_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrth_cfg_regs
// APB register file holding model flags, intercepts and weight lanes.
// ----------------------------------------------------------------------------
module lrth_cfg_regs import lrth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  cfg_reg_e   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_reg_e'(paddr[APB_ADDR_W-1:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLAGS:     cfg_q.flags               <= pwdata[FLAGS_W-1:0];
        REG_OBS_ICPT:  cfg_q.intercept[HEAD_OBS]  <= pwdata[ICPT_W-1:0];
        REG_DROP_ICPT: cfg_q.intercept[HEAD_DROP] <= pwdata[ICPT_W-1:0];
        REG_OBS_WLO:   cfg_q.w_low[HEAD_OBS]      <= pwdata;
        REG_OBS_WHI:   cfg_q.w_high[HEAD_OBS]     <= pwdata;
        REG_DROP_WLO:  cfg_q.w_low[HEAD_DROP]     <= pwdata;
        REG_DROP_WHI:  cfg_q.w_high[HEAD_DROP]    <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_FLAGS:     prdata = APB_DATA_W'(cfg_q.flags);
      REG_OBS_ICPT:  prdata = APB_DATA_W'(cfg_q.intercept[HEAD_OBS]);
      REG_DROP_ICPT: prdata = APB_DATA_W'(cfg_q.intercept[HEAD_DROP]);
      REG_OBS_WLO:   prdata = cfg_q.w_low[HEAD_OBS];
      REG_OBS_WHI:   prdata = cfg_q.w_high[HEAD_OBS];
      REG_DROP_WLO:  prdata = cfg_q.w_low[HEAD_DROP];
      REG_DROP_WHI:  prdata = cfg_q.w_high[HEAD_DROP];
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/lrth_logit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrth_logit
// One head's logit pipeline: products, two partial sums, intercept add,
// then saturation check and sigmoid table address.
// ----------------------------------------------------------------------------
module lrth_logit import lrth_pkg::*; (
  input  logic                     clk_i,
  input  feat_vec_t                feat_i,
  input  feat_vec_t                weight_i,
  input  logic signed [ICPT_W-1:0] intercept_i,
  output lut_req_t                 lut_o
);

  localparam logic signed [LOGIT_W-1:0] LIMIT_POS = LOGIT_W'(LOGIT_LIMIT);
  localparam logic signed [LOGIT_W-1:0] LIMIT_NEG = -LOGIT_W'(LOGIT_LIMIT);

  logic signed [PROD_W-1:0]  prod_d [FEATURE_COUNT];
  logic signed [PROD_W-1:0]  prod_q [FEATURE_COUNT];
  logic signed [PSUM_W-1:0]  psum_lo_d, psum_hi_d;
  logic signed [PSUM_W-1:0]  psum_lo_q, psum_hi_q;
  logic signed [LOGIT_W-1:0] logit_d, logit_q;
  logic [LOGIT_W-1:0]        mag_full;
  logic [IDX_FULL_W-1:0]     idx_full;

  // lane products, one multiplier each
  always_comb begin
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      prod_d[i] = PROD_W'($signed(weight_i[i])) * PROD_W'($signed(feat_i[i]));
    end
  end

  // partial sums over the low and high lane groups
  always_comb begin
    psum_lo_d = '0;
    psum_hi_d = '0;
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      if (i < HALF_LANES) begin
        psum_lo_d = psum_lo_d + PSUM_W'(prod_q[i]);
      end else begin
        psum_hi_d = psum_hi_d + PSUM_W'(prod_q[i]);
      end
    end
  end

  // intercept plus both partial sums
  assign logit_d = LOGIT_W'(intercept_i) + LOGIT_W'(psum_lo_q) + LOGIT_W'(psum_hi_q);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FEATURE_COUNT; i++) begin
      prod_q[i] <= prod_d[i];
    end
    psum_lo_q <= psum_lo_d;
    psum_hi_q <= psum_hi_d;
    logit_q   <= logit_d;
  end

  // saturation flags from the logit, table address from the magnitude
  assign mag_full = logit_q[LOGIT_W-1] ? LOGIT_W'(-logit_q) : LOGIT_W'(logit_q);
  assign idx_full = mag_full[MAG_W-1:IDX_SHIFT];

  always_comb begin
    lut_o.sat_hi = (logit_q >= LIMIT_POS);
    lut_o.sat_lo = (logit_q <= LIMIT_NEG);
    lut_o.neg    = logit_q[LOGIT_W-1];
    if (32'(idx_full) > 32'(SIG_DEPTH - 1)) begin
      lut_o.addr = SIG_ADDR_W'(SIG_DEPTH - 1);
    end else begin
      lut_o.addr = SIG_ADDR_W'(idx_full);
    end
  end

endmodule

>>> design/lrth_sig_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrth_sig_rom
// Sigmoid table with two registered read ports, one per head.
// ----------------------------------------------------------------------------
module lrth_sig_rom import lrth_pkg::*; (
  input  logic                  clk_i,
  input  logic [SIG_ADDR_W-1:0] addr_a_i,
  input  logic [SIG_ADDR_W-1:0] addr_b_i,
  output logic [PROB_W-1:0]     data_a_o,
  output logic [PROB_W-1:0]     data_b_o
);

  localparam sig_rom_t ROM_DATA = build_sig_rom();

  logic [PROB_W-1:0] data_a_q, data_b_q;

  // registered reads
  always_ff @(posedge clk_i) begin
    data_a_q <= ROM_DATA[addr_a_i];
    data_b_q <= ROM_DATA[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

>>> design/logistic_risk_two_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_risk_two_head
// Two-head logistic regression risk estimator (obstacle and drop).
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the eight Q8.8 features and two Q1.15 fallbacks and pulse
//   start. A transfer happens at each rising edge with start high and busy
//   low; busy stays low, so one item can be taken every cycle.
//   Output: done_o is high for one cycle with obstacle_prob_o and drop_prob_o
//   (Q1.15, 32768 is 1.0). The receiver must take the transfer in that cycle.
//   Pipeline: an item's result passes in order through the input register,
//   products, partial sums, logit, sigmoid table read and result register.
//   Throughput is one item per cycle, set by the fully pipelined datapath
//   with one multiplier per lane and a two-port table.
//   Configuration: APB port, 64-bit registers at 8-byte steps. Write only
//   while no item is in flight.
//   Reset: clears the pipeline valid bits and all configuration registers;
//   with the model off each head passes its fallback clamped to 0..1.
// ----------------------------------------------------------------------------
module logistic_risk_two_head import lrth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  logic signed [FEAT_W-1:0] slope_abs_i,
  input  logic signed [FEAT_W-1:0] roughness_i,
  input  logic signed [FEAT_W-1:0] height_sigma_i,
  input  logic signed [FEAT_W-1:0] step_up_i,
  input  logic signed [FEAT_W-1:0] height_span_i,
  input  logic signed [FEAT_W-1:0] obstacle_proxy_i,
  input  logic signed [FEAT_W-1:0] drop_proxy_i,
  input  logic signed [FEAT_W-1:0] climbable_prob_i,
  input  logic signed [FB_W-1:0]   obstacle_fallback_i,
  input  logic signed [FB_W-1:0]   drop_fallback_i,
  // result channel
  output logic                  done_o,
  output logic [PROB_W-1:0]     obstacle_prob_o,
  output logic [PROB_W-1:0]     drop_prob_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PIPE_STAGES = 5;

  cfg_t              cfg;
  logic              in_xfer;
  logic [PIPE_STAGES-1:0] vld_d, vld_q;
  logic              done_q;
  feat_vec_t         feat_q;
  feat_vec_t         weights [NUM_HEADS];
  logic [PROB_W-1:0] fb_clamp [NUM_HEADS];
  logic [PROB_W-1:0] fb_q [NUM_HEADS][PIPE_STAGES];
  lut_req_t          lut_req [NUM_HEADS];
  lut_req_t          lut_q [NUM_HEADS];
  logic [PROB_W-1:0] rom_data [NUM_HEADS];
  logic [NUM_HEADS-1:0] head_active;
  logic [PROB_W-1:0] prob_d [NUM_HEADS];
  logic [PROB_W-1:0] prob_q [NUM_HEADS];

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  lrth_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // fallback clamp to 0..1.0
  function automatic logic [PROB_W-1:0] clamp_fb(logic signed [FB_W-1:0] fb);
    logic [PROB_W-1:0] res;
    if (fb[FB_W-1]) begin
      res = '0;
    end else if (fb[PROB_W-1:0] > PROB_ONE) begin
      res = PROB_ONE;
    end else begin
      res = fb[PROB_W-1:0];
    end
    return res;
  endfunction

  assign fb_clamp[HEAD_OBS]  = clamp_fb(obstacle_fallback_i);
  assign fb_clamp[HEAD_DROP] = clamp_fb(drop_fallback_i);

  // input register and fallback delay line
  always_ff @(posedge clk_i) begin
    feat_q <= {climbable_prob_i, drop_proxy_i, obstacle_proxy_i, height_span_i,
               step_up_i, height_sigma_i, roughness_i, slope_abs_i};
    for (int h = 0; h < NUM_HEADS; h++) begin
      fb_q[h][0] <= fb_clamp[h];
      for (int s = 1; s < PIPE_STAGES; s++) begin
        fb_q[h][s] <= fb_q[h][s-1];
      end
    end
  end

  // per-head weight lanes, lane 0 in the low bits of the low register
  always_comb begin
    for (int h = 0; h < NUM_HEADS; h++) begin
      weights[h] = feat_vec_t'({cfg.w_high[h], cfg.w_low[h]});
    end
  end

  lrth_logit u_logit_obs (
    .clk_i       (clk_i),
    .feat_i      (feat_q),
    .weight_i    (weights[HEAD_OBS]),
    .intercept_i ($signed(cfg.intercept[HEAD_OBS])),
    .lut_o       (lut_req[HEAD_OBS])
  );

  lrth_logit u_logit_drop (
    .clk_i       (clk_i),
    .feat_i      (feat_q),
    .weight_i    (weights[HEAD_DROP]),
    .intercept_i ($signed(cfg.intercept[HEAD_DROP])),
    .lut_o       (lut_req[HEAD_DROP])
  );

  lrth_sig_rom u_rom (
    .clk_i    (clk_i),
    .addr_a_i (lut_req[HEAD_OBS].addr),
    .addr_b_i (lut_req[HEAD_DROP].addr),
    .data_a_o (rom_data[HEAD_OBS]),
    .data_b_o (rom_data[HEAD_DROP])
  );

  // saturation flags ride alongside the table read
  always_ff @(posedge clk_i) begin
    for (int h = 0; h < NUM_HEADS; h++) begin
      lut_q[h] <= lut_req[h];
    end
  end

  // head enable from model flags
  always_comb begin
    for (int h = 0; h < NUM_HEADS; h++) begin
      head_active[h] = cfg.flags[FLAG_MODEL_ON] & cfg.flags[FLAG_HEAD_ON + h] &
                       cfg.flags[FLAG_HEAD_W + h];
    end
  end

  // result select
  always_comb begin
    for (int h = 0; h < NUM_HEADS; h++) begin
      if (!head_active[h]) begin
        prob_d[h] = fb_q[h][PIPE_STAGES-1];
      end else if (lut_q[h].sat_hi) begin
        prob_d[h] = PROB_ONE;
      end else if (lut_q[h].sat_lo) begin
        prob_d[h] = '0;
      end else if (lut_q[h].neg) begin
        prob_d[h] = PROB_ONE - rom_data[h];
      end else begin
        prob_d[h] = rom_data[h];
      end
    end
  end

  // valid pipeline
  assign vld_d = {vld_q[PIPE_STAGES-2:0], in_xfer};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[PIPE_STAGES-1];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (vld_q[PIPE_STAGES-1]) begin
      for (int h = 0; h < NUM_HEADS; h++) begin
        prob_q[h] <= prob_d[h];
      end
    end
  end

  assign done_o          = done_q;
  assign obstacle_prob_o = prob_q[HEAD_OBS];
  assign drop_prob_o     = prob_q[HEAD_DROP];

endmodule
